@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the wheel load transfer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WLT_ASSERT_IMPL(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked on every clock edge outside reset.
`define WLT_ASSERT_HOLD(name, ck, rn, expr, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error(msg);

`endif

@@ rtl/core/wlt_pkg.sv @@
// ----------------------------------------------------------------------------
// wlt_pkg
// Shared types, constants and saturation helper for the wheel load transfer.
// ----------------------------------------------------------------------------
package wlt_pkg;

    localparam int LOAD_W   = 32;
    localparam int QUOT_W   = 32;
    localparam int DEN_W    = 34;
    localparam int WT_W     = 33;
    localparam int PROD_W   = 65;
    localparam int MAG_W    = 63;
    localparam int FRONT_LAT  = 3;
    localparam int SPLIT_LAT  = 1;
    localparam int DIV_LAT    = QUOT_W + 3;
    localparam int FINISH_LAT = 2;
    localparam int PIPE_LAT   = FRONT_LAT + SPLIT_LAT + DIV_LAT + FINISH_LAT;

    localparam logic [2:0] CASE_NONE  = 3'd0;
    localparam logic [2:0] CASE_AXLE  = 3'd1;
    localparam logic [2:0] CASE_SIDE  = 3'd2;
    localparam logic [2:0] CASE_FRONT = 3'd3;
    localparam logic [2:0] CASE_REAR  = 3'd4;

    localparam logic [2:0] REG_STATIC_FRONT = 3'd0;
    localparam logic [2:0] REG_STATIC_REAR  = 3'd1;
    localparam logic [2:0] REG_AERO_FRONT   = 3'd2;
    localparam logic [2:0] REG_AERO_REAR    = 3'd3;
    localparam logic [2:0] REG_LAT_FRONT    = 3'd4;
    localparam logic [2:0] REG_LAT_REAR     = 3'd5;
    localparam logic [2:0] REG_LONG         = 3'd6;
    localparam logic [2:0] REG_GUARD        = 3'd7;

    localparam logic [15:0] GUARD_RESET = 16'd655;

    typedef struct packed {
        logic signed [31:0] static_front;
        logic signed [31:0] static_rear;
        logic signed [31:0] aero_front;
        logic signed [31:0] aero_rear;
        logic signed [31:0] lat_front;
        logic signed [31:0] lat_rear;
        logic signed [31:0] long_c;
        logic [15:0]        guard;
    } cfg_t;

    typedef struct packed {
        logic sg_pos;
        logic sg_neg;
    } lat_sign_t;

    typedef struct packed {
        lat_sign_t             sg;
        logic [3:0][31:0]      ld;
        logic signed [31:0]    wtx;
        logic signed [31:0]    wty;
    } front_t;

    typedef struct packed {
        logic [2:0]       rcase;
        lat_sign_t        sg;
        logic [3:0][31:0] ld;
    } side_t;

    typedef struct packed {
        logic signed [WT_W-1:0]   wt;
        logic signed [LOAD_W-1:0] def;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/wheel_load_transfer_unit.sv @@
// ----------------------------------------------------------------------------
// wheel_load_transfer_unit
// Four wheel loads from acceleration and speed, with negative-load
// redistribution, in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One request is taken every cycle. Each result appears on done in order,
// for one cycle; the receiver cannot stall and nothing is buffered. The
// pipeline runs through three stages of load arithmetic, one stage of case
// selection, four identical share dividers, each a multiply stage, a setup
// stage, 32 quotient stages and a saturation stage, and two stages of final
// clamping.
// busy is high only while reset is asserted. Registers are written with
// cfg_write; write them only when no request is in flight.
module wheel_load_transfer_unit
    import wlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] accel_long,
    input  logic signed [15:0] accel_lat,
    input  logic [15:0]        vehicle_speed,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] load_front_first,
    output logic signed [31:0] load_front_second,
    output logic signed [31:0] load_rear_first,
    output logic signed [31:0] load_rear_second,
    output logic [2:0]         redistribution_case
);

    cfg_t                    cfg_reg;
    logic                    accept;
    logic                    front_valid;
    front_t                  front_data;
    logic                    split_valid;
    side_t                   split_side;
    div_req_t [3:0]          split_req;
    logic signed [DEN_W-1:0] split_den;
    logic [3:0][31:0]        shares;
    logic                    dly_valid_reg [DIV_LAT];
    side_t                   dly_side_reg  [DIV_LAT];

    assign busy   = ~rst_n;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.static_front <= '0;
            cfg_reg.static_rear  <= '0;
            cfg_reg.aero_front   <= '0;
            cfg_reg.aero_rear    <= '0;
            cfg_reg.lat_front    <= '0;
            cfg_reg.lat_rear     <= '0;
            cfg_reg.long_c       <= '0;
            cfg_reg.guard        <= GUARD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STATIC_FRONT: cfg_reg.static_front <= cfg_data;
                REG_STATIC_REAR:  cfg_reg.static_rear  <= cfg_data;
                REG_AERO_FRONT:   cfg_reg.aero_front   <= cfg_data;
                REG_AERO_REAR:    cfg_reg.aero_rear    <= cfg_data;
                REG_LAT_FRONT:    cfg_reg.lat_front    <= cfg_data;
                REG_LAT_REAR:     cfg_reg.lat_rear     <= cfg_data;
                REG_LONG:         cfg_reg.long_c       <= cfg_data;
                REG_GUARD:        cfg_reg.guard        <= cfg_data[15:0];
                default:          cfg_reg.guard        <= cfg_reg.guard;
            endcase
        end
    end

    wlt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .accel_long    (accel_long),
        .accel_lat     (accel_lat),
        .vehicle_speed (vehicle_speed),
        .cfg           (cfg_reg),
        .out_valid     (front_valid),
        .out_data      (front_data)
    );

    wlt_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .guard     (cfg_reg.guard),
        .out_valid (split_valid),
        .out_side  (split_side),
        .out_req   (split_req),
        .out_den   (split_den)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_div
        logic signed [31:0] share_w;
        wlt_div u_div (
            .clk   (clk),
            .req   (split_req[g]),
            .den   (split_den),
            .share (share_w)
        );
        assign shares[g] = share_w;
    end

    // side data travels alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                dly_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dly_valid_reg[0] <= split_valid;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dly_valid_reg[i] <= dly_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dly_side_reg[0] <= split_side;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            dly_side_reg[i] <= dly_side_reg[i-1];
        end
    end

    wlt_finish u_finish (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (dly_valid_reg[DIV_LAT-1]),
        .in_side             (dly_side_reg[DIV_LAT-1]),
        .in_share            (shares),
        .done                (done),
        .load_front_first    (load_front_first),
        .load_front_second   (load_front_second),
        .load_rear_first     (load_rear_first),
        .load_rear_second    (load_rear_second),
        .redistribution_case (redistribution_case)
    );

endmodule

@@ rtl/core/wlt_front.sv @@
// ----------------------------------------------------------------------------
// wlt_front
// Raw wheel loads: products, aero terms and saturated sums over three stages.
// ----------------------------------------------------------------------------
module wlt_front
    import wlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] accel_long,
    input  logic signed [15:0] accel_lat,
    input  logic [15:0]        vehicle_speed,
    input  cfg_t               cfg,
    output logic               out_valid,
    output front_t             out_data
);

    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        vsq_reg;
    logic signed [39:0] latf1_reg, latr1_reg, lng1_reg;
    lat_sign_t          sg1_reg;
    logic signed [48:0] aerof_reg, aeror_reg;
    logic signed [39:0] latf2_reg, latr2_reg, lng2_reg;
    lat_sign_t          sg2_reg;
    front_t             out_reg;

    logic signed [47:0] p_latf, p_latr, p_lng;
    logic signed [64:0] p_aerof, p_aeror;
    logic signed [63:0] sum [4];
    front_t             out_next;

    always_comb
    begin
        p_latf = 48'(cfg.lat_front) * 48'(accel_lat);
        p_latr = 48'(cfg.lat_rear) * 48'(accel_lat);
        p_lng  = 48'(cfg.long_c) * 48'(accel_long);
    end

    always_comb
    begin
        p_aerof = 65'(cfg.aero_front) * $signed({33'd0, vsq_reg});
        p_aeror = 65'(cfg.aero_rear) * $signed({33'd0, vsq_reg});
    end

    always_comb
    begin
        sum[0] = 64'(cfg.static_front) + 64'(aerof_reg) - 64'(latf2_reg) - 64'(lng2_reg);
        sum[1] = 64'(cfg.static_front) + 64'(aerof_reg) + 64'(latf2_reg) - 64'(lng2_reg);
        sum[2] = 64'(cfg.static_rear) + 64'(aeror_reg) - 64'(latr2_reg) + 64'(lng2_reg);
        sum[3] = 64'(cfg.static_rear) + 64'(aeror_reg) + 64'(latr2_reg) + 64'(lng2_reg);
        out_next.sg  = sg2_reg;
        for (int i = 0; i < 4; i++)
        begin
            out_next.ld[i] = sat32(sum[i]);
        end
        out_next.wtx = sat32(64'(lng2_reg));
        out_next.wty = sat32(64'(latf2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vsq_reg    <= 32'(vehicle_speed) * 32'(vehicle_speed);
        latf1_reg  <= 40'(p_latf >>> 8);
        latr1_reg  <= 40'(p_latr >>> 8);
        lng1_reg   <= 40'(p_lng >>> 8);
        sg1_reg.sg_pos <= (accel_lat > 16'sd0);
        sg1_reg.sg_neg <= accel_lat[15];

        aerof_reg <= 49'(p_aerof >>> 16);
        aeror_reg <= 49'(p_aeror >>> 16);
        latf2_reg <= latf1_reg;
        latr2_reg <= latr1_reg;
        lng2_reg  <= lng1_reg;
        sg2_reg   <= sg1_reg;

        out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/core/wlt_split.sv @@
// ----------------------------------------------------------------------------
// wlt_split
// Clamp, case selection, pair redistribution and divider operand setup.
// ----------------------------------------------------------------------------
module wlt_split
    import wlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  front_t                  in_data,
    input  logic [15:0]             guard,
    output logic                    out_valid,
    output side_t                   out_side,
    output div_req_t [3:0]          out_req,
    output logic signed [DEN_W-1:0] out_den
);

    logic                    valid_reg;
    side_t                   side_reg;
    div_req_t [3:0]          req_reg;
    logic signed [DEN_W-1:0] den_reg;

    logic signed [31:0]      ld [4];
    logic signed [31:0]      ng [4];
    logic signed [31:0]      ps [4];
    logic [3:0]              neg;
    logic signed [DEN_W-1:0] awy, gd, den3, den4;
    logic signed [WT_W-1:0]  wtx_e, wty_e, nwtx;
    side_t                   side_next;
    div_req_t [3:0]          req_next;
    logic signed [DEN_W-1:0] den_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ld[i]  = $signed(in_data.ld[i]);
            neg[i] = ld[i][31];
            ng[i]  = neg[i] ? ld[i] : 32'sd0;
            ps[i]  = neg[i] ? 32'sd0 : ld[i];
        end
        awy   = in_data.wty[31] ? -DEN_W'(in_data.wty) : DEN_W'(in_data.wty);
        gd    = $signed({18'd0, guard});
        den3  = DEN_W'(in_data.wtx) + awy + gd;
        den4  = -DEN_W'(in_data.wtx) + awy + gd;
        wtx_e = WT_W'(in_data.wtx);
        wty_e = WT_W'(in_data.wty);
        nwtx  = -WT_W'(in_data.wtx);

        side_next.sg = in_data.sg;
        for (int i = 0; i < 4; i++)
        begin
            side_next.ld[i] = ps[i];
        end
        req_next = '0;
        den_next = '0;
        side_next.rcase = CASE_NONE;

        if ((neg[0] && neg[1]) || (neg[2] && neg[3]))
        begin
            side_next.rcase = CASE_AXLE;
            side_next.ld[0] = ps[0] + ng[2];
            side_next.ld[1] = ps[1] + ng[3];
            side_next.ld[2] = ps[2] + ng[0];
            side_next.ld[3] = ps[3] + ng[1];
        end
        else if ((neg[0] && neg[2]) || (neg[1] && neg[3]))
        begin
            side_next.rcase = CASE_SIDE;
            side_next.ld[0] = ps[0] + ng[1];
            side_next.ld[1] = ps[1] + ng[0];
            side_next.ld[2] = ps[2] + ng[3];
            side_next.ld[3] = ps[3] + ng[2];
        end
        else if (neg[0] || neg[1])
        begin
            side_next.rcase = CASE_FRONT;
            den_next = den3;
            req_next[0] = '{wt: wtx_e, def: ng[1]};
            req_next[1] = '{wt: wtx_e, def: ng[0]};
            req_next[2] = '{wt: wty_e, def: ng[0]};
            req_next[3] = '{wt: wty_e, def: ng[1]};
        end
        else if (neg[2] || neg[3])
        begin
            side_next.rcase = CASE_REAR;
            den_next = den4;
            req_next[0] = '{wt: wty_e, def: ng[2]};
            req_next[1] = '{wt: wty_e, def: ng[3]};
            req_next[2] = '{wt: nwtx, def: ng[3]};
            req_next[3] = '{wt: nwtx, def: ng[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        req_reg  <= req_next;
        den_reg  <= den_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_req   = req_reg;
    assign out_den   = den_reg;

endmodule

@@ rtl/core/wlt_div.sv @@
// ----------------------------------------------------------------------------
// wlt_div
// Pipelined share unit: (wt * deficit) / den, truncated, saturated to 32 bits.
// One quotient bit per stage; quotients of 2^32 and above saturate early.
// ----------------------------------------------------------------------------
module wlt_div
    import wlt_pkg::*;
(
    input  logic                    clk,
    input  div_req_t                req,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [31:0]      share
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DEN_W-1:0]  den_a_reg;

    logic [DEN_W-1:0]  rem_reg  [QUOT_W+1];
    logic [QUOT_W-1:0] low_reg  [QUOT_W+1];
    logic [DEN_W-1:0]  dmag_reg [QUOT_W+1];
    logic              neg_reg  [QUOT_W+1];
    logic              ovf_reg  [QUOT_W+1];
    logic              dz_reg   [QUOT_W+1];
    logic signed [31:0] share_reg;

    logic signed [PROD_W-1:0] pabs;
    logic [MAG_W-1:0]         mag;
    logic signed [DEN_W-1:0]  dabs;
    logic [DEN_W-1:0]         dmag;
    logic [DEN_W:0]           trial [QUOT_W+1];
    logic                     ge    [QUOT_W+1];
    logic [DEN_W:0]           diff  [QUOT_W+1];
    logic [QUOT_W-1:0]        q;
    logic signed [31:0]       share_next;

    always_comb
    begin
        pabs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        mag  = pabs[MAG_W-1:0];
        dabs = den_a_reg[DEN_W-1] ? -den_a_reg : den_a_reg;
        dmag = dabs;
    end

    always_comb
    begin
        trial[0] = '0;
        ge[0]    = 1'b0;
        diff[0]  = '0;
        for (int i = 1; i <= QUOT_W; i++)
        begin
            trial[i] = {rem_reg[i-1], low_reg[i-1][QUOT_W-1]};
            ge[i]    = trial[i] >= {1'b0, dmag_reg[i-1]};
            diff[i]  = trial[i] - {1'b0, dmag_reg[i-1]};
        end
    end

    always_comb
    begin
        q = low_reg[QUOT_W];
        if (dz_reg[QUOT_W])
        begin
            share_next = 32'sd0;
        end
        else if (ovf_reg[QUOT_W])
        begin
            share_next = neg_reg[QUOT_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else if (neg_reg[QUOT_W])
        begin
            share_next = (q > 32'h80000000) ? 32'sh80000000 : -$signed(q);
        end
        else
        begin
            share_next = q[31] ? 32'sh7FFFFFFF : $signed(q);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(req.wt) * PROD_W'(req.def);
        den_a_reg <= den;

        rem_reg[0]  <= DEN_W'(mag[MAG_W-1:QUOT_W]);
        low_reg[0]  <= mag[QUOT_W-1:0];
        dmag_reg[0] <= dmag;
        neg_reg[0]  <= prod_reg[PROD_W-1] ^ den_a_reg[DEN_W-1];
        ovf_reg[0]  <= DEN_W'(mag[MAG_W-1:QUOT_W]) >= dmag;
        dz_reg[0]   <= (den_a_reg == '0);

        for (int i = 1; i <= QUOT_W; i++)
        begin
            rem_reg[i]  <= ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            low_reg[i]  <= {low_reg[i-1][QUOT_W-2:0], ge[i]};
            dmag_reg[i] <= dmag_reg[i-1];
            neg_reg[i]  <= neg_reg[i-1];
            ovf_reg[i]  <= ovf_reg[i-1];
            dz_reg[i]   <= dz_reg[i-1];
        end

        share_reg <= share_next;
    end

    assign share = share_reg;

endmodule

@@ rtl/core/wlt_finish.sv @@
// ----------------------------------------------------------------------------
// wlt_finish
// Applies single-wheel shares, second clamp pass and the result register.
// ----------------------------------------------------------------------------
module wlt_finish
    import wlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  side_t              in_side,
    input  logic [3:0][31:0]   in_share,
    output logic               done,
    output logic signed [31:0] load_front_first,
    output logic signed [31:0] load_front_second,
    output logic signed [31:0] load_rear_first,
    output logic signed [31:0] load_rear_second,
    output logic [2:0]         redistribution_case
);

    logic               v1_reg, done_reg;
    logic [2:0]         case1_reg, case_out_reg;
    logic signed [31:0] p_reg   [4];
    logic signed [31:0] n_reg   [4];
    logic signed [31:0] out_reg [4];

    logic               single;
    logic               use_sg;
    logic signed [32:0] sv      [4];
    logic signed [31:0] t       [4];
    logic signed [31:0] p_next  [4];
    logic signed [31:0] n_next  [4];
    logic signed [32:0] hsum;
    logic signed [31:0] h;
    logic signed [31:0] out_next [4];

    always_comb
    begin
        single = (in_side.rcase == CASE_FRONT) || (in_side.rcase == CASE_REAR);
        for (int i = 0; i < 4; i++)
        begin
            use_sg = ((in_side.rcase == CASE_FRONT) && (i >= 2)) ||
                     ((in_side.rcase == CASE_REAR) && (i < 2));
            if (!use_sg)
            begin
                sv[i] = 33'($signed(in_share[i]));
            end
            else if (in_side.sg.sg_pos)
            begin
                sv[i] = 33'($signed(in_share[i]));
            end
            else if (in_side.sg.sg_neg)
            begin
                sv[i] = -33'($signed(in_share[i]));
            end
            else
            begin
                sv[i] = 33'sd0;
            end
            t[i] = sat32(64'($signed(in_side.ld[i])) + 64'(sv[i]));
            if (single)
            begin
                p_next[i] = t[i][31] ? 32'sd0 : t[i];
                n_next[i] = t[i][31] ? t[i] : 32'sd0;
            end
            else
            begin
                p_next[i] = $signed(in_side.ld[i]);
                n_next[i] = 32'sd0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            out_next[i] = p_reg[i];
        end
        hsum = 33'sd0;
        h    = 32'sd0;
        case (case1_reg)
            CASE_FRONT:
            begin
                hsum = 33'(n_reg[0]) + 33'(n_reg[1]);
                h    = 32'(hsum >>> 1);
                out_next[0] = sat32(64'(sat32(64'(p_reg[0]) + 64'(n_reg[3]))) + 64'(h));
                out_next[1] = sat32(64'(sat32(64'(p_reg[1]) + 64'(n_reg[2]))) + 64'(h));
            end
            CASE_REAR:
            begin
                hsum = 33'(n_reg[2]) + 33'(n_reg[3]);
                h    = 32'(hsum >>> 1);
                out_next[2] = sat32(64'(p_reg[2]) + 64'(n_reg[1]));
                out_next[3] = sat32(64'(p_reg[3]) + 64'(n_reg[0]));
                out_next[0] = sat32(64'(p_reg[0]) + 64'(h));
                out_next[1] = sat32(64'(p_reg[1]) + 64'(h));
            end
            default:
            begin
                hsum = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case1_reg    <= in_side.rcase;
        case_out_reg <= case1_reg;
        for (int i = 0; i < 4; i++)
        begin
            p_reg[i]   <= p_next[i];
            n_reg[i]   <= n_next[i];
            out_reg[i] <= out_next[i];
        end
    end

    assign done                = done_reg;
    assign load_front_first    = out_reg[0];
    assign load_front_second   = out_reg[1];
    assign load_rear_first     = out_reg[2];
    assign load_rear_second    = out_reg[3];
    assign redistribution_case = case_out_reg;

endmodule

@@ rtl/core/wlt_checker.sv @@
// ----------------------------------------------------------------------------
// wlt_checker
// Port-level timing and result checks for the wheel load transfer unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wlt_checker
    import wlt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] load_front_first,
    input logic signed [31:0] load_front_second,
    input logic signed [31:0] load_rear_first,
    input logic signed [31:0] load_rear_second,
    input logic [2:0]         redistribution_case
);

    `WLT_ASSERT_IMPL(a_req_gives_result, clk, rst_n, start && !busy, ##PIPE_LAT done, "request lost")
    `WLT_ASSERT_IMPL(a_result_has_req, clk, rst_n, done, $past(start && !busy, PIPE_LAT), "spurious result")
    `WLT_ASSERT_HOLD(a_case_range, clk, rst_n, !done || (redistribution_case <= CASE_REAR), "bad case code")
    `WLT_ASSERT_IMPL(a_none_nonneg, clk, rst_n, done && (redistribution_case == CASE_NONE), !load_front_first[31] && !load_front_second[31] && !load_rear_first[31] && !load_rear_second[31], "negative load without redistribution")

endmodule

bind wheel_load_transfer_unit wlt_checker u_wlt_checker (.*);
